FILE: sv/lspg_pkg.sv
// Shared types, constants and the bar palette for the LED strip pattern generator.
`default_nettype none
package lspg_pkg;

  localparam int LED_COUNT_DEFAULT = 61;
  localparam int QUEUE_DEPTH       = 2;
  localparam int CFG_INDEX_W       = 3;
  localparam int CFG_DATA_W        = 16;
  localparam int LIMIT_W           = 16;
  localparam int BYTE_W            = 8;
  localparam int PALETTE_SIZE      = 7;
  localparam int PAL_W             = 3;

  // register indexes on the config port
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_GREEN_LIMIT  = 3'd0,
    REG_YELLOW_LIMIT = 3'd1,
    REG_ORANGE_LIMIT = 3'd2,
    REG_RED_LIMIT    = 3'd3,
    REG_OFFSET_STEP  = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    MODE_GRADIENT = 1'b0,
    MODE_BAR      = 1'b1
  } mode_t;

  // frame descriptor: start offset (gradient) or clamped bar length (bar)
  typedef struct packed {
    mode_t             mode;
    logic [BYTE_W-1:0] value;
  } desc_t;

  // palette color in wire order {first, second, third}
  function automatic logic [3*BYTE_W-1:0] palette_color(input logic [PAL_W-1:0] sel);
    logic [3*BYTE_W-1:0] c;
    case (sel)
      3'd0:    c = 24'h00FF00;
      3'd1:    c = 24'h45FF00;
      3'd2:    c = 24'hFFFF00;
      3'd3:    c = 24'hFF0000;
      3'd4:    c = 24'hBF00FF;
      3'd5:    c = 24'h0000FF;
      3'd6:    c = 24'h2B8AE2;
      default: c = 24'h000000;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: sv/lspg_front.sv
// Front end: config registers, command accept and classification into a frame descriptor.
`default_nettype none
module lspg_front #(
  parameter int LED_COUNT = lspg_pkg::LED_COUNT_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [lspg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [lspg_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             start,
  input  wire logic                             command,
  input  wire logic [lspg_pkg::LIMIT_W-1:0]     distance,
  input  wire logic                             full,
  output logic                                  busy,
  output logic                                  push,
  output lspg_pkg::desc_t                       desc
);

  logic [lspg_pkg::LIMIT_W-1:0] green_limit;
  logic [lspg_pkg::LIMIT_W-1:0] yellow_limit;
  logic [lspg_pkg::LIMIT_W-1:0] orange_limit;
  logic [lspg_pkg::LIMIT_W-1:0] red_limit;
  logic [lspg_pkg::BYTE_W-1:0]  offset_step;
  logic [lspg_pkg::BYTE_W-1:0]  step2;
  logic [lspg_pkg::BYTE_W-1:0]  step3;
  logic [lspg_pkg::BYTE_W-1:0]  offset;
  logic [lspg_pkg::BYTE_W-1:0]  bar_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      green_limit  <= 16'd200;
      yellow_limit <= 16'd150;
      orange_limit <= 16'd100;
      red_limit    <= 16'd50;
      offset_step  <= 8'd60;
    end else if (cfg_we) begin
      case (cfg_index)
        lspg_pkg::REG_GREEN_LIMIT:  green_limit  <= cfg_data;
        lspg_pkg::REG_YELLOW_LIMIT: yellow_limit <= cfg_data;
        lspg_pkg::REG_ORANGE_LIMIT: orange_limit <= cfg_data;
        lspg_pkg::REG_RED_LIMIT:    red_limit    <= cfg_data;
        lspg_pkg::REG_OFFSET_STEP:  offset_step  <= cfg_data[lspg_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // offsets only matter mod 256, so 8-bit wraparound is exact
  assign step2 = {offset_step[lspg_pkg::BYTE_W-2:0], 1'b0};
  assign step3 = step2 + offset_step;

  always_comb begin
    if (distance > green_limit)       offset = '0;
    else if (distance > yellow_limit) offset = offset_step;
    else if (distance > orange_limit) offset = step2;
    else if (distance > red_limit)    offset = step3;
    else                              offset = '0;
  end

  assign bar_len = (distance > lspg_pkg::LIMIT_W'(LED_COUNT)) ?
                   lspg_pkg::BYTE_W'(LED_COUNT) : distance[lspg_pkg::BYTE_W-1:0];

  assign busy = full;
  assign push = start && !full;

  always_comb begin
    desc.mode  = lspg_pkg::mode_t'(command);
    desc.value = command ? bar_len : offset;
  end

endmodule
`default_nettype wire

FILE: sv/lspg_queue.sv
// Small descriptor queue between the front end and the pixel engine.
`default_nettype none
module lspg_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  lspg_pkg::desc_t      push_desc,
  input  wire logic            pop,
  output lspg_pkg::desc_t      head,
  output logic                 empty,
  output logic                 full
);

  localparam int DEPTH = lspg_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lspg_pkg::desc_t  mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CNT_W'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) full |-> !empty)
    else $error("queue full and empty at once");
  assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count missed a push");

endmodule
`default_nettype wire

FILE: sv/lspg_back.sv
// Pixel engine: walks one frame per descriptor and registers one pixel word per cycle.
`default_nettype none
module lspg_back #(
  parameter int LED_COUNT = lspg_pkg::LED_COUNT_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  lspg_pkg::desc_t                    head,
  input  wire logic                          empty,
  output logic                               pop,
  output logic                               pixel_valid,
  output logic [lspg_pkg::BYTE_W-1:0]        first_byte,
  output logic [lspg_pkg::BYTE_W-1:0]        second_byte,
  output logic [lspg_pkg::BYTE_W-1:0]        third_byte,
  output logic                               last_pixel
);

  localparam int IDX_W = $clog2(LED_COUNT);

  logic                        active;
  logic [IDX_W-1:0]            idx;
  logic [lspg_pkg::PAL_W-1:0]  pal;
  lspg_pkg::desc_t             cur;
  logic                        at_last;
  logic [lspg_pkg::BYTE_W-1:0] idx_byte;
  logic [lspg_pkg::BYTE_W-1:0] grad_v;
  logic [3*lspg_pkg::BYTE_W-1:0] color;

  assign at_last  = (idx == IDX_W'(LED_COUNT - 1));
  assign pop      = !empty && (!active || at_last);
  assign idx_byte = lspg_pkg::BYTE_W'(idx);
  assign grad_v   = cur.value + idx_byte;

  always_comb begin
    if (cur.mode == lspg_pkg::MODE_GRADIENT) begin
      color = {~grad_v, grad_v, 8'h00};
    end else if (idx_byte < cur.value) begin
      color = lspg_pkg::palette_color(pal);
    end else begin
      color = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      idx         <= '0;
      pal         <= '0;
      pixel_valid <= 1'b0;
      last_pixel  <= 1'b0;
    end else begin
      pixel_valid <= active;
      last_pixel  <= active && at_last;
      if (pop) begin
        active <= 1'b1;
        idx    <= '0;
        pal    <= '0;
      end else if (active && at_last) begin
        active <= 1'b0;
      end else if (active) begin
        idx <= idx + 1'b1;
        pal <= (pal == lspg_pkg::PAL_W'(lspg_pkg::PALETTE_SIZE - 1)) ? '0 : pal + 1'b1;
      end
    end
  end

  // descriptor and pixel payload need no reset
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    first_byte  <= color[3*lspg_pkg::BYTE_W-1:2*lspg_pkg::BYTE_W];
    second_byte <= color[2*lspg_pkg::BYTE_W-1:lspg_pkg::BYTE_W];
    third_byte  <= color[lspg_pkg::BYTE_W-1:0];
  end

  assert property (@(posedge clk) disable iff (rst) last_pixel |-> pixel_valid)
    else $error("last_pixel without a pixel word");
  assert property (@(posedge clk) disable iff (rst)
    (active && !at_last) |=> (active && idx == $past(idx) + 1'b1))
    else $error("frame walk broke off early");
  assert property (@(posedge clk) disable iff (rst)
    (active && at_last && !empty) |=> (active && idx == '0))
    else $error("queued frame did not follow back to back");

endmodule
`default_nettype wire

FILE: sv/led_strip_pattern_generator.sv
// Top level of the LED strip pattern generator: front end, descriptor queue, pixel engine.
`default_nettype none
// Usage:
//   Command channel: a word (command, distance) is taken at a clock edge where
//   start is high and busy is low. command 0 asks for a gradient frame whose
//   start offset comes from the distance band; command 1 asks for a palette
//   bar of distance pixels, clamped to the strip length.
//   Result channel: each command yields LED_COUNT pixel words, one per cycle,
//   on first_byte/second_byte/third_byte with pixel_valid high for one cycle;
//   last_pixel marks the final word of a frame. The receiver cannot stall;
//   every word is taken in the cycle it is shown.
//   Config port: cfg_we writes cfg_data to register cfg_index at the clock
//   edge (0 green, 1 yellow, 2 orange, 3 red limit, 4 offset step); other
//   indexes are dropped. Write only while no frame is pending.
//   When the engine is idle, a command goes into the descriptor queue, is
//   popped into the pixel engine, and its first pixel word is registered.
//   The pixel engine emits one pixel per cycle; queued frames follow with no gap.
//   busy rises only when the descriptor queue is full.
//   Reset: clears the queue and engine, and loads the register defaults.
module led_strip_pattern_generator #(
  parameter int LED_COUNT = lspg_pkg::LED_COUNT_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [lspg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [lspg_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             command,
  input  wire logic [lspg_pkg::LIMIT_W-1:0]     distance,
  output logic                                  pixel_valid,
  output logic [lspg_pkg::BYTE_W-1:0]           first_byte,
  output logic [lspg_pkg::BYTE_W-1:0]           second_byte,
  output logic [lspg_pkg::BYTE_W-1:0]           third_byte,
  output logic                                  last_pixel
);

  lspg_pkg::desc_t push_desc;
  lspg_pkg::desc_t head;
  logic            push;
  logic            pop;
  logic            empty;
  logic            full;

  // accept and classify: band offset or clamped bar length
  lspg_front #(.LED_COUNT(LED_COUNT)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .start     (start),
    .command   (command),
    .distance  (distance),
    .full      (full),
    .busy      (busy),
    .push      (push),
    .desc      (push_desc)
  );

  // decouples command accept from the frame walk
  lspg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  // one pixel word per cycle, registered outputs
  lspg_back #(.LED_COUNT(LED_COUNT)) u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .pixel_valid (pixel_valid),
    .first_byte  (first_byte),
    .second_byte (second_byte),
    .third_byte  (third_byte),
    .last_pixel  (last_pixel)
  );

endmodule
`default_nettype wire
